@@ rtl/arpc_pkg.sv @@
`timescale 1ns / 1ps

package arpc_pkg;

   // Table geometry
   localparam int ENTRIES = 64;
   localparam int IDX_W   = 6;
   localparam int CNT_W   = 7;
   localparam int IP_W    = 32;
   localparam int MAC_W   = 48;
   localparam int STAT_W  = 3;

   // Request codes
   localparam logic FUNC_LOOKUP = 1'b0;
   localparam logic FUNC_ADD    = 1'b1;

   // Response status codes
   localparam logic [STAT_W-1:0] ST_MISS     = 3'd0;
   localparam logic [STAT_W-1:0] ST_HIT      = 3'd1;
   localparam logic [STAT_W-1:0] ST_INSERTED = 3'd2;
   localparam logic [STAT_W-1:0] ST_UPDATED  = 3'd3;
   localparam logic [STAT_W-1:0] ST_FULL     = 3'd4;

   // Search token stepping down the row of cells
   typedef struct packed {
      logic             valid;
      logic             hit;
      logic [IDX_W-1:0] idx;
      logic [MAC_W-1:0] mac;
   } tok_type;

   // Broadcast write into one cell
   typedef struct packed {
      logic             en;
      logic             ip_en;
      logic [IDX_W-1:0] idx;
      logic [IP_W-1:0]  ip;
      logic [MAC_W-1:0] mac;
   } wr_type;

endpackage

@@ rtl/arpc_if.sv @@
`timescale 1ns / 1ps

interface arpc_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic [31:0] ip_addr;
   logic [47:0] mac_addr;

   modport source (output valid, output func, output ip_addr, output mac_addr, input ready);
   modport sink   (input valid, input func, input ip_addr, input mac_addr, output ready);
endinterface

interface arpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [47:0] found_mac;
   logic [5:0]  entry_index;
   logic [6:0]  fill_count;

   modport source (output valid, output status, output found_mac, output entry_index,
                   output fill_count, input ready);
   modport sink   (input valid, input status, input found_mac, input entry_index,
                   input fill_count, output ready);
endinterface

@@ rtl/arpc_cell.sv @@
`timescale 1ns / 1ps

module arpc_cell (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [arpc_pkg::IDX_W-1:0] cell_index,
   input  logic [arpc_pkg::IP_W-1:0]  key,
   input  logic [arpc_pkg::CNT_W-1:0] count,
   input  arpc_pkg::wr_type        wr,
   input  arpc_pkg::tok_type       tok_in,
   output arpc_pkg::tok_type       tok_out
);
   import arpc_pkg::*;

   logic [IP_W-1:0]  ip_ff;
   logic [MAC_W-1:0] mac_ff;
   logic             tok_valid_ff;
   logic             tok_hit_ff;
   logic [IDX_W-1:0] tok_idx_ff;
   logic [MAC_W-1:0] tok_mac_ff;
   logic             filled;
   logic             match;
   logic             sel;

   // Store the entry on a write aimed at this cell
   assign sel = wr.en && (wr.idx == cell_index);

   always_ff @(posedge clock) begin
      if (sel) begin
         mac_ff <= wr.mac;
         if (wr.ip_en) begin
            ip_ff <= wr.ip;
         end
      end
   end

   // Compare only entries below the fill count; the first match claims the token
   assign filled = ({1'b0, cell_index} < count);
   assign match  = tok_in.valid && !tok_in.hit && filled && (ip_ff == key);

   always_ff @(posedge clock) begin
      if (reset) begin
         tok_valid_ff <= 1'b0;
      end else begin
         tok_valid_ff <= tok_in.valid;
      end
   end

   // Advance the token payload to the next cell
   always_ff @(posedge clock) begin
      tok_hit_ff <= tok_in.hit || match;
      tok_idx_ff <= match ? cell_index : tok_in.idx;
      tok_mac_ff <= match ? mac_ff : tok_in.mac;
   end

   assign tok_out.valid = tok_valid_ff;
   assign tok_out.hit   = tok_hit_ff;
   assign tok_out.idx   = tok_idx_ff;
   assign tok_out.mac   = tok_mac_ff;

endmodule

@@ rtl/arp_cache_table.sv @@
`timescale 1ns / 1ps
// Each request passes the launch, search and done states before its response is registered.
// The search token steps one cell per cycle down the row of ENTRIES cells, and a request
// is taken only when the row is idle, so the next request waits until this one is resolved.
// A finished response waits in the output register while the next request is taken.
// Reset: synchronous, active high; clears the fill count and control state. The stored
// addresses are not cleared; entries at or above the fill count are never compared.

module arp_cache_table (
   input  logic       clock,
   input  logic       reset,
   arpc_req_if.sink   req_chan,
   arpc_rsp_if.source rsp_chan
);
   import arpc_pkg::*;

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_LAUNCH = 2'd1;
   localparam logic [1:0] S_SEARCH = 2'd2;
   localparam logic [1:0] S_DONE   = 2'd3;

   logic [1:0]        state_ff, state_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              func_ff;
   logic [IP_W-1:0]   key_ff;
   logic [MAC_W-1:0]  mac_ff;
   logic              cap_hit_ff;
   logic [IDX_W-1:0]  cap_idx_ff;
   logic [MAC_W-1:0]  cap_mac_ff;
   logic              rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0] rsp_status_ff, rsp_status_in;
   logic [MAC_W-1:0]  rsp_mac_ff, rsp_mac_in;
   logic [IDX_W-1:0]  rsp_idx_ff, rsp_idx_in;
   logic [CNT_W-1:0]  rsp_count_ff, rsp_count_in;
   logic              req_beat;
   logic              out_free;
   wr_type            wr;
   tok_type           tok_chain [ENTRIES+1];
   logic [ENTRIES-1:0] tok_vld;

   assign req_beat       = req_chan.valid && req_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE);
   assign out_free       = !rsp_valid_ff || rsp_chan.ready;

   // Inject a fresh token at the head of the row
   assign tok_chain[0].valid = (state_ff == S_LAUNCH);
   assign tok_chain[0].hit   = 1'b0;
   assign tok_chain[0].idx   = '0;
   assign tok_chain[0].mac   = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      arpc_cell u_cell (
         .clock      (clock),
         .reset      (reset),
         .cell_index (IDX_W'(i)),
         .key        (key_ff),
         .count      (count_ff),
         .wr         (wr),
         .tok_in     (tok_chain[i]),
         .tok_out    (tok_chain[i+1])
      );
      assign tok_vld[i] = tok_chain[i+1].valid;
   end

   // Sequence one request: launch, search, then resolve and write back
   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in = rsp_status_ff;
      rsp_mac_in    = rsp_mac_ff;
      rsp_idx_in    = rsp_idx_ff;
      rsp_count_in  = rsp_count_ff;
      wr.en         = 1'b0;
      wr.ip_en      = 1'b0;
      wr.idx        = cap_idx_ff;
      wr.ip         = key_ff;
      wr.mac        = mac_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (req_beat) begin
               state_in = S_LAUNCH;
            end
         end
         S_LAUNCH: begin
            state_in = S_SEARCH;
         end
         S_SEARCH: begin
            if (tok_chain[ENTRIES].valid) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               rsp_mac_in   = '0;
               rsp_idx_in   = '0;
               if (func_ff == FUNC_LOOKUP) begin
                  if (cap_hit_ff) begin
                     rsp_status_in = ST_HIT;
                     rsp_mac_in    = cap_mac_ff;
                     rsp_idx_in    = cap_idx_ff;
                  end else begin
                     rsp_status_in = ST_MISS;
                  end
               end else if (cap_hit_ff) begin
                  rsp_status_in = ST_UPDATED;
                  rsp_idx_in    = cap_idx_ff;
                  wr.en         = 1'b1;
               end else if (count_ff != CNT_W'(ENTRIES)) begin
                  rsp_status_in = ST_INSERTED;
                  rsp_idx_in    = count_ff[IDX_W-1:0];
                  wr.en         = 1'b1;
                  wr.ip_en      = 1'b1;
                  wr.idx        = count_ff[IDX_W-1:0];
                  count_in      = count_ff + CNT_W'(1);
               end else begin
                  rsp_status_in = ST_FULL;
               end
               rsp_count_in = count_in;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Hold the request beat and the search outcome; load the response register
   always_ff @(posedge clock) begin
      if (req_beat) begin
         func_ff <= req_chan.func;
         key_ff  <= req_chan.ip_addr;
         mac_ff  <= req_chan.mac_addr;
      end
      if (state_ff == S_SEARCH && tok_chain[ENTRIES].valid) begin
         cap_hit_ff <= tok_chain[ENTRIES].hit;
         cap_idx_ff <= tok_chain[ENTRIES].idx;
         cap_mac_ff <= tok_chain[ENTRIES].mac;
      end
      rsp_status_ff <= rsp_status_in;
      rsp_mac_ff    <= rsp_mac_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_count_ff  <= rsp_count_in;
   end

   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.found_mac   = rsp_mac_ff;
   assign rsp_chan.entry_index = rsp_idx_ff;
   assign rsp_chan.fill_count  = rsp_count_ff;

   // Checks
   a_one_token: assert property (@(posedge clock) disable iff (reset)
      $countones(tok_vld) <= 1)
      else $error("more than one search token in the row");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(ENTRIES))
      else $error("fill count above table size");

   a_token_exit: assert property (@(posedge clock) disable iff (reset)
      tok_chain[ENTRIES].valid |-> state_ff == S_SEARCH)
      else $error("token left the row outside of a search");

   a_done_resp: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && out_free) |=> rsp_valid_ff)
      else $error("resolved request produced no response beat");

endmodule
